FILE: design/cscs_pkg.sv
`timescale 1ns / 1ps
package cscs_pkg;

  localparam int unsigned CLICK_LENGTH = 3528;
  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned SINE_AW = $clog2(SINE_ENTRIES + 1);

  localparam logic [31:0] SEED_RESET = 32'h0000_DEAD;
  localparam logic [23:0] ENV_ONE = 24'hFF_FFFF;
  localparam logic [23:0] SNAP_INC = 24'd532610;
  localparam logic [23:0] BASE_INC = 24'd133153;
  localparam logic [24:0] MULT_SNAP = 25'd16650882;
  localparam logic [24:0] MULT_BODY = 25'd16758205;
  localparam logic [24:0] MULT_SWEEP = 25'd16751873;
  localparam logic [24:0] MULT_NOISE = 25'd16682376;
  localparam logic [24:0] AMP_SNAP = 25'd26214;
  localparam logic [24:0] AMP_BODY = 25'd52429;
  localparam logic [24:0] AMP_NOISE = 25'd7864;
  localparam logic [24:0] LCG_MUL = 25'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [24:0] OUT_SCALE = 25'd32767;
  localparam logic signed [26:0] SUM_MAX = 27'sd16777216;
  localparam logic signed [26:0] SUM_MIN = -27'sd16777216;
  localparam logic [3:0] REG_SEED = 4'd0;

  typedef logic [16:0] sine_rom_t [0:SINE_ENTRIES];

  function automatic sine_rom_t build_sine_rom();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    sine_rom_t rom;
    for (int k = 0; k <= int'(SINE_ENTRIES); k++) begin
      x = (longint'(k) * 64'd1686629713) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      t = 64'd1073741824;
      t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
      t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
      t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      s = (((x * t) >> 30) + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      rom[k] = s[16:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_START,
    OP_SNAP_M1,
    OP_SNAP_M2,
    OP_BODY_M1,
    OP_BODY_M2,
    OP_LCG,
    OP_NOISE_M1,
    OP_NOISE_M2,
    OP_SUM,
    OP_SCALE,
    OP_D_SNAP,
    OP_D_BODY,
    OP_D_SWEEP,
    OP_D_NOISE,
    OP_ADV,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_SNAP_M1,
    ST_SNAP_M2,
    ST_BODY_M1,
    ST_BODY_M2,
    ST_LCG,
    ST_NOISE_M1,
    ST_NOISE_M2,
    ST_SUM,
    ST_SCALE,
    ST_D_SNAP,
    ST_D_BODY,
    ST_D_SWEEP,
    ST_D_NOISE,
    ST_ADV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic slot_free;
  } status_t;

  function automatic logic signed [25:0] apply_sign(input logic neg, input logic [24:0] mag);
    logic signed [25:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic [SINE_AW-1:0] sine_addr(input logic [23:0] phase);
    logic [35:0] scaled;
    logic [SINE_AW-1:0] idx;
    scaled = 36'(phase[21:0]) * 36'(SINE_ENTRIES);
    idx = SINE_AW'(scaled >> 22);
    return phase[22] ? SINE_AW'(SINE_ENTRIES) - idx : idx;
  endfunction

endpackage

FILE: design/cscs_ctrl.sv
`timescale 1ns / 1ps
module cscs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cscs_pkg::status_t status,
  output cscs_pkg::cmd_t    cmd
);

  cscs_pkg::state_t state;
  cscs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cscs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cscs_pkg::ST_IDLE:     if (in_valid) state_next = cscs_pkg::ST_START;
      cscs_pkg::ST_START:    state_next = status.active ? cscs_pkg::ST_SNAP_M1
                                                        : cscs_pkg::ST_EMIT;
      cscs_pkg::ST_SNAP_M1:  state_next = cscs_pkg::ST_SNAP_M2;
      cscs_pkg::ST_SNAP_M2:  state_next = cscs_pkg::ST_BODY_M1;
      cscs_pkg::ST_BODY_M1:  state_next = cscs_pkg::ST_BODY_M2;
      cscs_pkg::ST_BODY_M2:  state_next = cscs_pkg::ST_LCG;
      cscs_pkg::ST_LCG:      state_next = cscs_pkg::ST_NOISE_M1;
      cscs_pkg::ST_NOISE_M1: state_next = cscs_pkg::ST_NOISE_M2;
      cscs_pkg::ST_NOISE_M2: state_next = cscs_pkg::ST_SUM;
      cscs_pkg::ST_SUM:      state_next = cscs_pkg::ST_SCALE;
      cscs_pkg::ST_SCALE:    state_next = cscs_pkg::ST_D_SNAP;
      cscs_pkg::ST_D_SNAP:   state_next = cscs_pkg::ST_D_BODY;
      cscs_pkg::ST_D_BODY:   state_next = cscs_pkg::ST_D_SWEEP;
      cscs_pkg::ST_D_SWEEP:  state_next = cscs_pkg::ST_D_NOISE;
      cscs_pkg::ST_D_NOISE:  state_next = cscs_pkg::ST_ADV;
      cscs_pkg::ST_ADV:      state_next = cscs_pkg::ST_EMIT;
      cscs_pkg::ST_EMIT:     if (status.slot_free) state_next = cscs_pkg::ST_IDLE;
      default:               state_next = cscs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op = cscs_pkg::OP_NONE;
    unique case (state)
      cscs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op = in_valid ? cscs_pkg::OP_ACCEPT : cscs_pkg::OP_NONE;
      end
      cscs_pkg::ST_START:    cmd.op = cscs_pkg::OP_START;
      cscs_pkg::ST_SNAP_M1:  cmd.op = cscs_pkg::OP_SNAP_M1;
      cscs_pkg::ST_SNAP_M2:  cmd.op = cscs_pkg::OP_SNAP_M2;
      cscs_pkg::ST_BODY_M1:  cmd.op = cscs_pkg::OP_BODY_M1;
      cscs_pkg::ST_BODY_M2:  cmd.op = cscs_pkg::OP_BODY_M2;
      cscs_pkg::ST_LCG:      cmd.op = cscs_pkg::OP_LCG;
      cscs_pkg::ST_NOISE_M1: cmd.op = cscs_pkg::OP_NOISE_M1;
      cscs_pkg::ST_NOISE_M2: cmd.op = cscs_pkg::OP_NOISE_M2;
      cscs_pkg::ST_SUM:      cmd.op = cscs_pkg::OP_SUM;
      cscs_pkg::ST_SCALE:    cmd.op = cscs_pkg::OP_SCALE;
      cscs_pkg::ST_D_SNAP:   cmd.op = cscs_pkg::OP_D_SNAP;
      cscs_pkg::ST_D_BODY:   cmd.op = cscs_pkg::OP_D_BODY;
      cscs_pkg::ST_D_SWEEP:  cmd.op = cscs_pkg::OP_D_SWEEP;
      cscs_pkg::ST_D_NOISE:  cmd.op = cscs_pkg::OP_D_NOISE;
      cscs_pkg::ST_ADV:      cmd.op = cscs_pkg::OP_ADV;
      cscs_pkg::ST_EMIT:     cmd.op = cscs_pkg::OP_EMIT;
      default:               cmd.op = cscs_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: design/cscs_dp.sv
`timescale 1ns / 1ps
module cscs_dp (
  input  logic              clk,
  input  logic              rst,
  input  cscs_pkg::cmd_t     cmd,
  output cscs_pkg::status_t  status,
  input  logic              restart,
  input  logic [31:0]       seed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_sample,
  output logic              out_playing,
  output logic              out_last
);

  logic [cscs_pkg::IDX_W-1:0] sample_index;
  logic [31:0] noise_register;
  logic [23:0] snap_phase;
  logic [23:0] base_phase;
  logic [23:0] snap_envelope;
  logic [23:0] body_envelope;
  logic [23:0] sweep_envelope;
  logic [23:0] noise_envelope;

  logic [16:0] rom_q;
  logic        rom_neg;
  logic [cscs_pkg::SINE_AW-1:0] rom_addr;
  logic [23:0] rom_phase;
  logic        rom_rd;

  logic [56:0] p;
  logic        p_neg;
  logic [31:0] mul_a;
  logic [24:0] mul_b;

  logic signed [25:0] snap_val;
  logic signed [25:0] body_val;
  logic signed [25:0] sum_r;
  logic signed [26:0] sum_raw;
  logic [24:0] sum_mag;

  logic [15:0] res_sample;
  logic        res_playing;
  logic        res_last;

  logic [23:0] sweep_d;
  logic [29:0] sweep_x33;
  logic [23:0] sweep_phase;
  logic [31:0] lcg_next;
  logic [30:0] rn_mag;
  logic        slot_free;

  assign sweep_d = cscs_pkg::ENV_ONE - sweep_envelope;
  assign sweep_x33 = {1'b0, sweep_d, 5'b0} + 30'(sweep_d);
  assign sweep_phase = base_phase + sweep_x33[25:2];
  assign lcg_next = p[31:0] + cscs_pkg::LCG_ADD;
  assign rn_mag = lcg_next[31] ? {1'b0, lcg_next[30:1]}
                               : 31'h4000_0000 - {1'b0, lcg_next[30:1]};
  assign sum_raw = 27'(snap_val) + 27'(body_val)
                 + 27'(cscs_pkg::apply_sign(p_neg, p[40:16]));
  assign sum_mag = sum_r[25] ? 25'(-sum_r) : sum_r[24:0];
  assign slot_free = !out_valid || out_ready;

  assign status.active = sample_index < cscs_pkg::IDX_W'(cscs_pkg::CLICK_LENGTH);
  assign status.slot_free = slot_free;

  always_comb begin
    rom_rd = 1'b0;
    rom_phase = snap_phase;
    if (cmd.op == cscs_pkg::OP_START) begin
      rom_rd = 1'b1;
    end else if (cmd.op == cscs_pkg::OP_SNAP_M1) begin
      rom_rd = 1'b1;
      rom_phase = sweep_phase;
    end
    rom_addr = cscs_pkg::sine_addr(rom_phase);
  end

  always_ff @(posedge clk) begin
    if (rom_rd) begin
      rom_q <= cscs_pkg::SINE_ROM[rom_addr];
      rom_neg <= rom_phase[23];
    end
  end

  // one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      cscs_pkg::OP_SNAP_M1: begin
        mul_a = 32'(rom_q);
        mul_b = 25'(snap_envelope);
      end
      cscs_pkg::OP_SNAP_M2: begin
        mul_a = p[47:16];
        mul_b = cscs_pkg::AMP_SNAP;
      end
      cscs_pkg::OP_BODY_M1: begin
        mul_a = 32'(rom_q);
        mul_b = 25'(body_envelope);
      end
      cscs_pkg::OP_BODY_M2: begin
        mul_a = p[47:16];
        mul_b = cscs_pkg::AMP_BODY;
      end
      cscs_pkg::OP_LCG: begin
        mul_a = noise_register;
        mul_b = cscs_pkg::LCG_MUL;
      end
      cscs_pkg::OP_NOISE_M1: begin
        mul_a = 32'(rn_mag[30:6]);
        mul_b = 25'(noise_envelope);
      end
      cscs_pkg::OP_NOISE_M2: begin
        mul_a = p[55:24];
        mul_b = cscs_pkg::AMP_NOISE;
      end
      cscs_pkg::OP_SCALE: begin
        mul_a = 32'(sum_mag);
        mul_b = cscs_pkg::OUT_SCALE;
      end
      cscs_pkg::OP_D_SNAP: begin
        mul_a = 32'(snap_envelope);
        mul_b = cscs_pkg::MULT_SNAP;
      end
      cscs_pkg::OP_D_BODY: begin
        mul_a = 32'(body_envelope);
        mul_b = cscs_pkg::MULT_BODY;
      end
      cscs_pkg::OP_D_SWEEP: begin
        mul_a = 32'(sweep_envelope);
        mul_b = cscs_pkg::MULT_SWEEP;
      end
      cscs_pkg::OP_D_NOISE: begin
        mul_a = 32'(noise_envelope);
        mul_b = cscs_pkg::MULT_NOISE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= 57'(mul_a) * 57'(mul_b);
    case (cmd.op)
      cscs_pkg::OP_SNAP_M1, cscs_pkg::OP_BODY_M1: p_neg <= rom_neg;
      cscs_pkg::OP_NOISE_M1: p_neg <= !lcg_next[31];
      cscs_pkg::OP_SCALE:    p_neg <= sum_r[25];
      default:               p_neg <= p_neg;
    endcase
    if (cmd.op == cscs_pkg::OP_BODY_M1) snap_val <= cscs_pkg::apply_sign(p_neg, p[40:16]);
    if (cmd.op == cscs_pkg::OP_LCG) body_val <= cscs_pkg::apply_sign(p_neg, p[40:16]);
    if (cmd.op == cscs_pkg::OP_SUM) begin
      if (sum_raw > cscs_pkg::SUM_MAX) begin
        sum_r <= 26'(cscs_pkg::SUM_MAX);
      end else if (sum_raw < cscs_pkg::SUM_MIN) begin
        sum_r <= 26'(cscs_pkg::SUM_MIN);
      end else begin
        sum_r <= 26'(sum_raw);
      end
    end
    if (cmd.op == cscs_pkg::OP_START) begin
      res_sample <= '0;
      res_playing <= status.active;
      res_last <= sample_index == cscs_pkg::IDX_W'(cscs_pkg::CLICK_LENGTH - 1);
    end
    if (cmd.op == cscs_pkg::OP_D_SNAP) begin
      res_sample <= p_neg ? -p[39:24] : p[39:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= cscs_pkg::IDX_W'(cscs_pkg::CLICK_LENGTH);
      noise_register <= cscs_pkg::SEED_RESET;
      snap_phase <= '0;
      base_phase <= '0;
      snap_envelope <= cscs_pkg::ENV_ONE;
      body_envelope <= cscs_pkg::ENV_ONE;
      sweep_envelope <= cscs_pkg::ENV_ONE;
      noise_envelope <= cscs_pkg::ENV_ONE;
    end else begin
      unique case (cmd.op)
        cscs_pkg::OP_ACCEPT: begin
          if (restart) begin
            sample_index <= '0;
            noise_register <= seed;
            snap_phase <= '0;
            base_phase <= '0;
            snap_envelope <= cscs_pkg::ENV_ONE;
            body_envelope <= cscs_pkg::ENV_ONE;
            sweep_envelope <= cscs_pkg::ENV_ONE;
            noise_envelope <= cscs_pkg::ENV_ONE;
          end
        end
        cscs_pkg::OP_NOISE_M1: noise_register <= lcg_next;
        cscs_pkg::OP_D_BODY:   snap_envelope <= p[47:24];
        cscs_pkg::OP_D_SWEEP:  body_envelope <= p[47:24];
        cscs_pkg::OP_D_NOISE:  sweep_envelope <= p[47:24];
        cscs_pkg::OP_ADV: begin
          noise_envelope <= p[47:24];
          snap_phase <= snap_phase + cscs_pkg::SNAP_INC;
          base_phase <= base_phase + cscs_pkg::BASE_INC;
          sample_index <= sample_index + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == cscs_pkg::OP_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cscs_pkg::OP_EMIT && slot_free) begin
      out_sample <= res_sample;
      out_playing <= res_playing;
      out_last <= res_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    sample_index <= cscs_pkg::IDX_W'(cscs_pkg::CLICK_LENGTH))
    else $error("sample index past click end");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_playing |-> out_sample == '0)
    else $error("idle item with nonzero sample");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_playing)
    else $error("last flag on idle item");

endmodule

FILE: design/click_sound_synth_core.sv
`timescale 1ns / 1ps
// One-shot click generator: each accepted item (restart flag) yields one 16-bit
// sample. A click item is computed by the single shared multiplier, which is
// sequenced through the 12 products of a sample; an item after the click has
// ended returns zero. The next item is accepted in the cycle after the result is
// registered. A new item is accepted while the previous result still waits in
// the output register. The noise seed register sits at address 0, and its value
// is loaded into the noise register on every restart.
module click_sound_synth_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample
  output logic [0:0]  m_tuser,   // playing
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cscs_pkg::cmd_t    cmd;
  cscs_pkg::status_t status;
  logic [31:0] noise_seed;
  logic        seed_sel;

  assign pready = 1'b1;
  assign seed_sel = {1'b0, paddr[2]} == 2'(cscs_pkg::REG_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= cscs_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && seed_sel) begin
      noise_seed <= pwdata;
    end
  end

  assign prdata = seed_sel ? noise_seed : '0;

  cscs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cscs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .restart     (s_tdata[0]),
    .seed        (noise_seed),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_sample  (m_tdata),
    .out_playing (m_tuser[0]),
    .out_last    (m_tlast)
  );

endmodule
